/* hw/rtl/blra_pkg.sv */
// Shared widths, request and run codes, and word types for the block-aligned
// log ring allocator. No dependencies.

package blra_pkg;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 16;
    localparam int FILL_W = 17;
    localparam int KIND_W = 2;
    localparam int RUN_W  = 3;

    localparam int BLOCK_BYTES_DEF  = 512;
    localparam int RING_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 16;

    // request kinds; the fourth code is unused and is rejected
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

    // run kinds on the result channel
    localparam logic [RUN_W-1:0] RUN_HEADER = 3'd0;
    localparam logic [RUN_W-1:0] RUN_PAD    = 3'd1;
    localparam logic [RUN_W-1:0] RUN_PLACED = 3'd2;
    localparam logic [RUN_W-1:0] RUN_REJECT = 3'd3;
    localparam logic [RUN_W-1:0] RUN_DONE   = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] wp;
        logic [ADDR_W-1:0] rp;
        logic [FILL_W-1:0] fill;
    } ring_state_t;

    typedef struct packed {
        logic [RUN_W-1:0]  run_kind;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  run_length;
        logic              last;
    } run_word_t;

endpackage

/* hw/rtl/block_aligned_log_ring_allocator_top.sv */
// Top level of the block-aligned log ring allocator: request register, ring
// state, result register. Depends on blra_pkg and blra_step.
//
//  channel | direction | fields                                        | handshake
//  --------+-----------+-----------------------------------------------+-----------------
//  s_      | in        | kind, byte_count                              | s_valid/s_ready
//  m_      | out       | run_kind, start_address, run_length, last     | m_valid/m_ready
//
// A request gives one to three result words, one per cycle from the step unit
// while m_ready does not stall; the request register is held until its last word
// is loaded into the result register, so a one-word request can follow every cycle,
// and an allocate that pads and reserves a header holds it for three words.
// Synchronous active-low reset empties the ring (both pointers and fill zero).
// A stall on m_ready freezes the step unit and, while a request is held, s_ready.

module block_aligned_log_ring_allocator_top import blra_pkg::*; #(
    parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
    parameter int RING_BYTES   = RING_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [LEN_W-1:0]  s_byte_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RUN_W-1:0]  m_run_kind,
    output logic [ADDR_W-1:0] m_start_address,
    output logic [LEN_W-1:0]  m_run_length,
    output logic              m_last
);

    localparam int OFF_W = $clog2(BLOCK_BYTES);

    logic              busy_reg;
    logic [1:0]        step_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [LEN_W-1:0]  count_reg;
    ring_state_t       st_reg;
    ring_state_t       st_next;
    logic [OFF_W-1:0]  off_reg;
    logic [OFF_W-1:0]  off_next;
    logic              m_valid_reg;
    run_word_t         out_reg;
    run_word_t         step_res;

    logic step_fire;
    logic s_accept;

    blra_step #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_step (
        .kind        (kind_reg),
        .byte_count  (count_reg),
        .step_count  (step_reg),
        .st          (st_reg),
        .wr_off      (off_reg),
        .res         (step_res),
        .st_next     (st_next),
        .wr_off_next (off_next)
    );

    assign step_fire = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !busy_reg || (step_fire && step_res.last);
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            st_reg      <= '0;
            off_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (step_fire) begin
                st_reg      <= st_next;
                off_reg     <= off_next;
                m_valid_reg <= 1'b1;
                step_reg    <= step_reg + 2'd1;
                if (step_res.last) begin
                    busy_reg <= 1'b0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
        end
    end

    // payload words, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= s_kind;
            count_reg <= s_byte_count;
        end
        if (step_fire) begin
            out_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_run_kind      = out_reg.run_kind;
    assign m_start_address = out_reg.start_address;
    assign m_run_length    = out_reg.run_length;
    assign m_last          = out_reg.last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.fill <= FILL_W'(RING_BYTES - 1))
        else $error("fill count above usable ring size");

    a_off_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        off_reg < OFF_W'(BLOCK_BYTES - 1) || off_reg == OFF_W'(BLOCK_BYTES - 1))
        else $error("write block offset out of range");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg != 2'd3)
        else $error("more than three words for one request");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_valid_reg && !m_ready) |=> ($stable(st_reg) && $stable(off_reg)))
        else $error("ring state moved while result word stalled");

    a_more_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && !step_res.last) |=> (busy_reg && m_valid_reg))
        else $error("request dropped before its last word");
`endif

endmodule

/* hw/rtl/blra_step.sv */
// One allocation step: from the ring state and the held request, works out the
// next result word and the state after it. Depends on blra_pkg.

module blra_step import blra_pkg::*; #(
    parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
    parameter int RING_BYTES   = RING_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    localparam int OFF_W = $clog2(BLOCK_BYTES)
) (
    input  logic [KIND_W-1:0] kind,
    input  logic [LEN_W-1:0]  byte_count,
    input  logic [1:0]        step_count,
    input  ring_state_t       st,
    input  logic [OFF_W-1:0]  wr_off,
    output run_word_t         res,
    output ring_state_t       st_next,
    output logic [OFF_W-1:0]  wr_off_next
);

    localparam int SPC_W = $clog2(BLOCK_BYTES + 1);
    localparam logic [FILL_W-1:0] RING_K    = FILL_W'(RING_BYTES);
    localparam logic [FILL_W-1:0] FREE_MAX  = FILL_W'(RING_BYTES - 1);
    localparam logic [LEN_W-1:0]  MAX_ENTRY = LEN_W'(BLOCK_BYTES - HEADER_BYTES);
    localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(HEADER_BYTES);
    localparam logic [FILL_W-1:0] HDR_F     = FILL_W'(HEADER_BYTES);
    localparam logic [SPC_W-1:0]  BLOCK_S   = SPC_W'(BLOCK_BYTES);
    localparam logic [OFF_W:0]    BLOCK_O   = (OFF_W+1)'(BLOCK_BYTES);

    logic [SPC_W-1:0]  space;
    logic [FILL_W-1:0] space_f;
    logic [FILL_W-1:0] n_f;
    logic [FILL_W-1:0] fr;
    logic [FILL_W-1:0] lin;
    logic              at_block_start;
    logic              third_step;

    logic [LEN_W-1:0]  adv;
    logic              do_adv;
    logic [FILL_W-1:0] wsum;
    logic [FILL_W-1:0] wsub;
    logic              wwrap;
    logic [OFF_W:0]    osum;

    logic [FILL_W-1:0] rel_x;
    logic [FILL_W-1:0] rsum;
    logic [FILL_W-1:0] fill_rel;
    logic [ADDR_W-1:0] rp_rel;
    logic              realign;

    assign space          = BLOCK_S - SPC_W'(wr_off);
    assign space_f        = FILL_W'(space);
    assign n_f            = FILL_W'(byte_count);
    assign fr             = FREE_MAX - st.fill;
    assign at_block_start = (wr_off == '0);
    assign third_step     = (step_count == 2'd2);

    // contiguous room up to the ring end or the read pointer
    always_comb begin
        if (st.wp >= st.rp) begin
            lin = RING_K - FILL_W'(st.wp) - FILL_W'(st.rp == '0);
        end else begin
            lin = FILL_W'(st.rp) - FILL_W'(st.wp) - FILL_W'(1);
        end
    end

    // write-side advance; the block offset is tracked alongside the pointer
    assign wsum  = FILL_W'(st.wp) + FILL_W'(adv);
    assign wsub  = wsum - RING_K;
    assign wwrap = (wsum >= RING_K);
    assign osum  = (OFF_W+1)'(wr_off) + (OFF_W+1)'(adv[OFF_W-1:0]);

    // release side
    assign rel_x    = (n_f < st.fill) ? n_f : st.fill;
    assign rsum     = FILL_W'(st.rp) + rel_x;
    assign fill_rel = st.fill - rel_x;
    // empty ring means rp == wp, so its block offset is wr_off
    assign realign  = (fill_rel == '0) && !at_block_start;
    always_comb begin
        if (rsum >= RING_K) begin
            rp_rel = ADDR_W'(rsum - RING_K);
        end else begin
            rp_rel = ADDR_W'(rsum);
        end
    end

    always_comb begin
        res.run_kind      = RUN_REJECT;
        res.start_address = st.wp;
        res.run_length    = byte_count;
        res.last          = 1'b1;
        adv               = '0;
        do_adv            = 1'b0;
        case (kind)
            KIND_ALLOC: begin
                if (byte_count > MAX_ENTRY) begin
                    res.run_kind = RUN_REJECT;
                end else if (at_block_start) begin
                    if (!third_step && fr >= HDR_F) begin
                        res.run_kind   = RUN_HEADER;
                        res.run_length = HDR_LEN;
                        res.last       = 1'b0;
                        adv            = HDR_LEN;
                        do_adv         = 1'b1;
                    end
                end else if (n_f > space_f) begin
                    if (!third_step && space_f <= fr) begin
                        res.run_kind   = RUN_PAD;
                        res.run_length = LEN_W'(space);
                        res.last       = 1'b0;
                        adv            = LEN_W'(space);
                        do_adv         = 1'b1;
                    end
                end else if (n_f <= fr) begin
                    res.run_kind = RUN_PLACED;
                    adv          = byte_count;
                    do_adv       = 1'b1;
                end
            end
            KIND_FLUSH: begin
                if (at_block_start) begin
                    res.run_kind   = RUN_DONE;
                    res.run_length = '0;
                end else begin
                    res.run_length = LEN_W'(space);
                    if (fr >= space_f && lin >= space_f) begin
                        res.run_kind = RUN_PAD;
                        adv          = LEN_W'(space);
                        do_adv       = 1'b1;
                    end
                end
            end
            KIND_RELEASE: begin
                res.run_kind      = RUN_DONE;
                res.start_address = realign ? '0 : rp_rel;
                res.run_length    = LEN_W'(rel_x);
            end
            default: begin
                res.run_length = '0;
            end
        endcase
    end

    always_comb begin
        st_next     = st;
        wr_off_next = wr_off;
        if (kind == KIND_RELEASE) begin
            st_next.rp   = realign ? '0 : rp_rel;
            st_next.fill = fill_rel;
            if (realign) begin
                st_next.wp  = '0;
                wr_off_next = '0;
            end
        end else if (do_adv) begin
            st_next.fill = st.fill + FILL_W'(adv);
            if (wwrap) begin
                st_next.wp  = ADDR_W'(wsub);
                wr_off_next = OFF_W'(wsub);
            end else begin
                st_next.wp  = ADDR_W'(wsum);
                wr_off_next = (osum >= BLOCK_O) ? OFF_W'(osum - BLOCK_O) : OFF_W'(osum);
            end
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for block_aligned_log_ring_allocator_top: a ring
// tracker predicts every run word, bursty requests and a stalling receiver.
// Depends on blra_pkg and the allocator RTL.

module testbench;
    import blra_pkg::*;

    localparam int BLK  = BLOCK_BYTES_DEF;
    localparam int RING = RING_BYTES_DEF;
    localparam int HDR  = HEADER_BYTES_DEF;

    // spare request code, rejected by the block
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind = KIND_ALLOC;
    logic [LEN_W-1:0]  s_byte_count = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [RUN_W-1:0]  m_run_kind;
    logic [ADDR_W-1:0] m_start_address;
    logic [LEN_W-1:0]  m_run_length;
    logic              m_last;

    block_aligned_log_ring_allocator_top #(
        .BLOCK_BYTES (BLK),
        .RING_BYTES  (RING),
        .HEADER_BYTES(HDR)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_byte_count   (s_byte_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_kind     (m_run_kind),
        .m_start_address(m_start_address),
        .m_run_length   (m_run_length),
        .m_last         (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("block_aligned_log_ring_allocator_top regression: fail");
        $finish;
    end

    // ring tracker
    logic [ADDR_W-1:0] wr_ptr = '0;
    logic [ADDR_W-1:0] rd_ptr = '0;
    logic [FILL_W-1:0] used_bytes = '0;
    run_word_t         expected_runs[$];
    int                mismatch_count = 0;

    // sender burst state
    int burst_left = 0;

    // receiver stall pattern
    logic [15:0] ready_mask = '1;
    int unsigned ready_tick = 0;

    function automatic void push_run(logic [RUN_W-1:0] rk, int addr, int len, logic lst);
        run_word_t w;
        w.run_kind      = rk;
        w.start_address = ADDR_W'(addr);
        w.run_length    = LEN_W'(len);
        w.last          = lst;
        expected_runs.push_back(w);
    endfunction

    function automatic int free_bytes();
        return RING - 1 - int'(used_bytes);
    endfunction

    function automatic void bump_write(int n);
        wr_ptr     = ADDR_W'((int'(wr_ptr) + n) % RING);
        used_bytes = used_bytes + FILL_W'(n);
    endfunction

    function automatic void plan_allocate(int n);
        int off, room, avail, runs;
        bit placed, stop;
        runs   = 0;
        placed = 0;
        stop   = 0;
        if (n > BLK - HDR) begin
            push_run(RUN_REJECT, int'(wr_ptr), n, 1'b1);
            return;
        end
        while (!stop) begin
            off   = int'(wr_ptr) % BLK;
            room  = BLK - off;
            avail = free_bytes();
            if (off == 0) begin
                if (runs >= 2 || avail < HDR) begin
                    stop = 1;
                end else begin
                    push_run(RUN_HEADER, int'(wr_ptr), HDR, 1'b0);
                    runs++;
                    bump_write(HDR);
                end
            end else if (n > room) begin
                if (runs >= 2 || room > avail) begin
                    stop = 1;
                end else begin
                    push_run(RUN_PAD, int'(wr_ptr), room, 1'b0);
                    runs++;
                    bump_write(room);
                end
            end else begin
                if (n <= avail) begin
                    push_run(RUN_PLACED, int'(wr_ptr), n, 1'b1);
                    bump_write(n);
                    placed = 1;
                end
                stop = 1;
            end
        end
        // runs already reserved stay; the reject closes the request
        if (!placed)
            push_run(RUN_REJECT, int'(wr_ptr), n, 1'b1);
    endfunction

    function automatic void plan_flush();
        int off, pad, contiguous;
        off = int'(wr_ptr) % BLK;
        if (off == 0) begin
            push_run(RUN_DONE, int'(wr_ptr), 0, 1'b1);
            return;
        end
        pad = BLK - off;
        if (wr_ptr >= rd_ptr)
            contiguous = RING - int'(wr_ptr) - ((rd_ptr == 0) ? 1 : 0);
        else
            contiguous = int'(rd_ptr) - int'(wr_ptr) - 1;
        if (free_bytes() < pad || contiguous < pad) begin
            push_run(RUN_REJECT, int'(wr_ptr), pad, 1'b1);
        end else begin
            push_run(RUN_PAD, int'(wr_ptr), pad, 1'b1);
            bump_write(pad);
        end
    endfunction

    function automatic void plan_release(int n);
        int freed;
        freed      = (n < int'(used_bytes)) ? n : int'(used_bytes);
        rd_ptr     = ADDR_W'((int'(rd_ptr) + freed) % RING);
        used_bytes = used_bytes - FILL_W'(freed);
        // empty ring with the read side mid-block: both pointers realign
        if (used_bytes == 0 && (int'(rd_ptr) % BLK) != 0) begin
            rd_ptr = '0;
            wr_ptr = '0;
        end
        push_run(RUN_DONE, int'(rd_ptr), freed, 1'b1);
    endfunction

    function automatic void plan_request(logic [KIND_W-1:0] k, logic [LEN_W-1:0] n);
        case (k)
            KIND_ALLOC:   plan_allocate(int'(n));
            KIND_RELEASE: plan_release(int'(n));
            KIND_FLUSH:   plan_flush();
            default:      push_run(RUN_REJECT, int'(wr_ptr), 0, 1'b1);
        endcase
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] k, input logic [LEN_W-1:0] n);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_kind       <= k;
        s_byte_count <= n;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        plan_request(k, n);
    endtask

    task automatic report_mismatch(input string what, input run_word_t want,
                                   input run_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%0t mismatch (%s): expected kind %0d addr %0d len %0d last %0b,",
                   $realtime, what, want.run_kind, want.start_address,
                   want.run_length, want.last);
            $display(" got kind %0d addr %0d len %0d last %0b",
                     got.run_kind, got.start_address, got.run_length, got.last);
        end
    endtask

    always @(posedge aclk) begin : check_runs
        run_word_t want;
        run_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got.run_kind      = m_run_kind;
            got.start_address = m_start_address;
            got.run_length    = m_run_length;
            got.last          = m_last;
            if (expected_runs.size() == 0) begin
                report_mismatch("no word expected", '0, got);
            end else begin
                want = expected_runs.pop_front();
                if (got.run_kind !== want.run_kind
                    || got.start_address !== want.start_address
                    || got.run_length !== want.run_length
                    || got.last !== want.last)
                    report_mismatch("field", want, got);
            end
        end
    end

    // receiver: 16-bit ready mask stepped by the tick counter, redrawn when ready_tick[5:0] is zero, never all low
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick[5:0] == 6'd0)
            ready_mask <= ($urandom_range(99) < 25) ? 16'hFFFF
                          : (16'($urandom) | (16'h1 << $urandom_range(15)));
        m_ready <= ready_mask[ready_tick[3:0]];
    end

    task automatic test_allocate_edges();
        send_request(KIND_ALLOC, 16'd0);      // header then empty entry
        send_request(KIND_ALLOC, 16'd1);
        send_request(KIND_ALLOC, 16'd496);    // pad, header, entry
        send_request(KIND_ALLOC, 16'd497);    // just oversized
        send_request(KIND_ALLOC, 16'hFFFF);
        send_request(KIND_ALLOC, 16'd495);
    endtask

    task automatic test_flush_edges();
        send_request(KIND_FLUSH, 16'h5A5A);   // mid-block pad
        send_request(KIND_FLUSH, 16'hA5A5);   // already at block start
        send_request(KIND_ALLOC, 16'd5);
        send_request(KIND_FLUSH, 16'h0000);
    endtask

    task automatic test_release_edges();
        send_request(KIND_RELEASE, 16'd0);
        send_request(KIND_RELEASE, 16'hFFFF); // saturates at the fill
        send_request(KIND_ALLOC, 16'd10);
        send_request(KIND_RELEASE, 16'd26);   // empties mid-block, realign
        send_request(KIND_RELEASE, 16'd5);    // on an empty ring
    endtask

    task automatic test_unused_kind();
        send_request(KIND_SPARE, 16'hAAAA);
        send_request(KIND_SPARE, 16'h5555);
    endtask

    task automatic run_traffic(input int items, input int alloc_pct, input int release_pct,
                               input int flush_pct, input bit bulk);
        int i, pick, sel;
        logic [KIND_W-1:0] k;
        logic [LEN_W-1:0]  n;
        for (i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            sel  = $urandom_range(99);
            if (pick < alloc_pct) begin
                k = KIND_ALLOC;
                if (sel < 8)
                    n = LEN_W'($urandom_range(65535));
                else if (sel < 16)
                    n = LEN_W'($urandom_range(15));
                else
                    n = LEN_W'(bulk ? $urandom_range(400, BLK - HDR)
                                    : $urandom_range(0, BLK - HDR));
            end else if (pick < alloc_pct + release_pct) begin
                k = KIND_RELEASE;
                if (bulk)
                    n = LEN_W'($urandom_range(500, 3000));
                else
                    n = LEN_W'((sel < 30) ? $urandom_range(65535) : $urandom_range(600));
            end else if (pick < alloc_pct + release_pct + flush_pct) begin
                k = KIND_FLUSH;
                n = LEN_W'($urandom_range(65535));
            end else begin
                k = KIND_SPARE;
                n = LEN_W'($urandom_range(65535));
            end
            send_request(k, n);
        end
    endtask

    // fill the ring until header, pad and entry space all run out
    task automatic test_fill_ring();
        run_traffic(150, 92, 4, 3, 1'b1);
    endtask

    task automatic test_drain_ring();
        run_traffic(30, 15, 80, 4, 1'b1);
    endtask

    // write pointer wraps past the ring end here
    task automatic test_mixed_traffic();
        run_traffic(60, 60, 20, 15, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_allocate_edges();
        test_flush_edges();
        test_release_edges();
        test_unused_kind();
        test_fill_ring();
        test_drain_ring();
        test_mixed_traffic();
        s_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && expected_runs.size() == 0)
            $display("block_aligned_log_ring_allocator_top regression: pass");
        else
            $display("block_aligned_log_ring_allocator_top regression: fail");
        $finish;
    end

endmodule
